### design/kau_pkg.sv
package kau_pkg;

    localparam int KEY_WORDS_DEF = 5;
    localparam int WORD_BITS     = 32;
    localparam int OUT_KEY_BITS  = 160;
    localparam int SMALL_BITS    = 31;

    typedef enum logic [2:0] {
        KIND_ADD      = 3'd0,
        KIND_ADD_BYTE = 3'd1,
        KIND_SUB      = 3'd2,
        KIND_DIV      = 3'd3,
        KIND_XOR      = 3'd4,
        KIND_CMP      = 3'd5,
        KIND_MID      = 3'd6
    } kau_kind_t;

    typedef enum logic [1:0] {
        ORD_LESS    = 2'd0,
        ORD_EQUAL   = 2'd1,
        ORD_GREATER = 2'd2
    } kau_order_t;

    typedef struct packed {
        logic [2:0]            kind;
        logic [31:0]           a_top;
        logic [63:0]           a_mid;
        logic [63:0]           a_low;
        logic [31:0]           b_top;
        logic [63:0]           b_mid;
        logic [63:0]           b_low;
        logic [SMALL_BITS-1:0] small_operand;
    } kau_req_t;

    typedef struct packed {
        logic [31:0] r_top;
        logic [63:0] r_mid;
        logic [63:0] r_low;
        logic [1:0]  order;
        logic        div_error;
    } kau_res_t;

    typedef struct packed {
        logic       valid;
        logic       div;
        logic [1:0] order;
        logic       err;
    } kau_ctrl_t;

endpackage

### design/kau_front.sv
module kau_front #(
    parameter int KEY_BITS = 160
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  kau_pkg::kau_req_t           req,
    output kau_pkg::kau_ctrl_t          ctrl,
    output logic [kau_pkg::SMALL_BITS-1:0] dsr,
    output logic [KEY_BITS-1:0]         key
);
    import kau_pkg::*;

    logic [KEY_BITS+OUT_KEY_BITS-1:0] a_ext;
    logic [KEY_BITS+OUT_KEY_BITS-1:0] b_ext;
    logic [KEY_BITS-1:0]              a_in;
    logic [KEY_BITS-1:0]              b_in;
    logic [1:0]                       ord_in;

    logic                  s1_valid_reg;
    logic [2:0]            s1_kind_reg;
    logic [SMALL_BITS-1:0] s1_small_reg;
    logic [KEY_BITS-1:0]   s1_a_reg, s1_b_reg;
    logic [KEY_BITS-1:0]   s1_sum_reg, s1_abyte_reg, s1_dab_reg, s1_dba_reg;
    logic [1:0]            s1_ord_reg;

    kau_ctrl_t             ctrl_reg, ctrl_next;
    logic [SMALL_BITS-1:0] dsr_reg;
    logic [KEY_BITS-1:0]   key_reg, key_next;

    assign a_ext = {{KEY_BITS{1'b0}}, req.a_top, req.a_mid, req.a_low};
    assign b_ext = {{KEY_BITS{1'b0}}, req.b_top, req.b_mid, req.b_low};
    assign a_in  = a_ext[KEY_BITS-1:0];
    assign b_in  = b_ext[KEY_BITS-1:0];

    always_comb
    begin
        if (a_in < b_in)
            ord_in = ORD_LESS;
        else if (a_in == b_in)
            ord_in = ORD_EQUAL;
        else
            ord_in = ORD_GREATER;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        s1_kind_reg  <= req.kind;
        s1_small_reg <= req.small_operand;
        s1_a_reg     <= a_in;
        s1_b_reg     <= b_in;
        s1_ord_reg   <= ord_in;
        s1_sum_reg   <= a_in + b_in;
        s1_abyte_reg <= a_in + KEY_BITS'(req.small_operand[7:0]);
        s1_dab_reg   <= a_in - b_in;
        s1_dba_reg   <= b_in - a_in;
    end

    always_comb
    begin
        ctrl_next.valid = s1_valid_reg;
        ctrl_next.div   = 1'b0;
        ctrl_next.order = s1_ord_reg;
        ctrl_next.err   = 1'b0;
        key_next        = '0;
        case (kau_kind_t'(s1_kind_reg))
            KIND_ADD:      key_next = s1_sum_reg;
            KIND_ADD_BYTE: key_next = s1_abyte_reg;
            KIND_SUB:      key_next = s1_dab_reg;
            KIND_DIV:
            begin
                if (s1_small_reg == '0)
                    ctrl_next.err = 1'b1;
                else
                begin
                    ctrl_next.div = 1'b1;
                    key_next      = s1_a_reg;
                end
            end
            KIND_XOR:      key_next = s1_a_reg ^ s1_b_reg;
            KIND_CMP:      key_next = '0;
            KIND_MID:
            begin
                if (s1_ord_reg != ORD_GREATER)
                    key_next = s1_a_reg + (s1_dba_reg >> 1);
                else
                    key_next = s1_b_reg + (s1_dab_reg >> 1);
            end
            default:       key_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctrl_reg <= '0;
        else
            ctrl_reg <= ctrl_next;
    end

    always_ff @(posedge clk)
    begin
        dsr_reg        <= s1_small_reg;
        key_reg        <= key_next;
    end

    assign ctrl = ctrl_reg;
    assign dsr  = dsr_reg;
    assign key  = key_reg;

endmodule

### design/kau_cell.sv
module kau_cell #(
    parameter int KEY_BITS = 160
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  kau_pkg::kau_ctrl_t             ctrl_in,
    input  logic [kau_pkg::SMALL_BITS-1:0] dsr_in,
    input  logic [kau_pkg::SMALL_BITS-1:0] rem_in,
    input  logic [KEY_BITS-1:0]            key_in,
    output kau_pkg::kau_ctrl_t             ctrl_out,
    output logic [kau_pkg::SMALL_BITS-1:0] dsr_out,
    output logic [kau_pkg::SMALL_BITS-1:0] rem_out,
    output logic [KEY_BITS-1:0]            key_out
);
    import kau_pkg::*;

    logic [SMALL_BITS:0]   rem2;
    logic [SMALL_BITS:0]   rem_sub;
    logic                  ge;
    kau_ctrl_t             ctrl_reg;
    logic [SMALL_BITS-1:0] dsr_reg;
    logic [SMALL_BITS-1:0] rem_reg, rem_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;

    // one restoring division step, quotient bit shifted in at the bottom
    assign rem2    = {rem_in, key_in[KEY_BITS-1]};
    assign ge      = rem2 >= {1'b0, dsr_in};
    assign rem_sub = rem2 - {1'b0, dsr_in};

    always_comb
    begin
        if (ctrl_in.div)
        begin
            rem_next = ge ? rem_sub[SMALL_BITS-1:0] : rem2[SMALL_BITS-1:0];
            key_next = {key_in[KEY_BITS-2:0], ge};
        end
        else
        begin
            rem_next = rem_in;
            key_next = key_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctrl_reg <= '0;
        else
            ctrl_reg <= ctrl_in;
    end

    always_ff @(posedge clk)
    begin
        dsr_reg        <= dsr_in;
        rem_reg        <= rem_next;
        key_reg        <= key_next;
    end

    assign ctrl_out = ctrl_reg;
    assign dsr_out  = dsr_reg;
    assign rem_out  = rem_reg;
    assign key_out  = key_reg;

endmodule

### design/key_arithmetic_unit_160_unit.sv
// channel   | handshake            | payload
// request   | start in, busy out   | req  (kau_req_t)
// result    | done out             | res  (kau_res_t)
//
// one request per cycle
// the division chain computes one quotient bit per cell
// busy stays low; the pipeline never stalls and the receiver cannot stall
// reset clears only the control fields (valid, div, order, err) and done, not the data
module key_arithmetic_unit_160_unit #(
    parameter int KEY_WORDS = kau_pkg::KEY_WORDS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  kau_pkg::kau_req_t req,
    output logic              done,
    output kau_pkg::kau_res_t res
);
    import kau_pkg::*;

    localparam int KEY_BITS = WORD_BITS * KEY_WORDS;

    kau_ctrl_t             ctrl [0:KEY_BITS];
    logic [SMALL_BITS-1:0] dsr  [0:KEY_BITS];
    logic [SMALL_BITS-1:0] rem  [0:KEY_BITS];
    logic [KEY_BITS-1:0]   key  [0:KEY_BITS];

    logic [KEY_BITS+OUT_KEY_BITS-1:0] r_ext;
    logic                             done_reg;
    kau_res_t                         res_reg, res_next;

    assign busy = 1'b0;

    kau_front #(.KEY_BITS(KEY_BITS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start && !busy),
        .req      (req),
        .ctrl     (ctrl[0]),
        .dsr      (dsr[0]),
        .key      (key[0])
    );

    assign rem[0] = '0;

    for (genvar i = 0; i < KEY_BITS; i++)
    begin : g_cell
        kau_cell #(.KEY_BITS(KEY_BITS)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl_in  (ctrl[i]),
            .dsr_in   (dsr[i]),
            .rem_in   (rem[i]),
            .key_in   (key[i]),
            .ctrl_out (ctrl[i+1]),
            .dsr_out  (dsr[i+1]),
            .rem_out  (rem[i+1]),
            .key_out  (key[i+1])
        );
    end

    assign r_ext = {{OUT_KEY_BITS{1'b0}}, key[KEY_BITS]};

    always_comb
    begin
        res_next.r_top     = r_ext[159:128];
        res_next.r_mid     = r_ext[127:64];
        res_next.r_low     = r_ext[63:0];
        res_next.order     = ctrl[KEY_BITS].order;
        res_next.div_error = ctrl[KEY_BITS].err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= ctrl[KEY_BITS].valid;
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign done = done_reg;
    assign res  = res_reg;

    a_err_zero_key: assert property (@(posedge clk) disable iff (!rst_n)
        done && res.div_error |-> res.r_top == '0 && res.r_mid == '0 && res.r_low == '0)
        else $error("divide error with nonzero key");

    a_order_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> res.order != 2'd3)
        else $error("bad order code");

    a_div_no_err: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl[0].valid && ctrl[0].div |-> !ctrl[0].err && dsr[0] != '0)
        else $error("divide entered chain with zero divisor");

endmodule

### tb/kau_checker.sv
module kau_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  kau_pkg::kau_req_t req,
    input  logic              done,
    input  kau_pkg::kau_res_t res,
    output int                fail_count,
    output int                pending,
    output int                result_count
);
    import kau_pkg::*;

    kau_res_t want_q[$];

    function automatic kau_res_t key_result(input kau_req_t q);
        kau_res_t   r;
        logic [159:0] a;
        logic [159:0] b;
        logic [159:0] k;
        logic [1:0] ord;
        a = {q.a_top, q.a_mid, q.a_low};
        b = {q.b_top, q.b_mid, q.b_low};
        k = '0;
        r = '0;
        if (a < b)
            ord = ORD_LESS;
        else if (a == b)
            ord = ORD_EQUAL;
        else
            ord = ORD_GREATER;
        case (q.kind)
            KIND_ADD:      k = a + b;
            KIND_ADD_BYTE: k = a + {152'd0, q.small_operand[7:0]};
            KIND_SUB:      k = a - b;
            KIND_DIV:
            begin
                if (q.small_operand == '0)
                    r.div_error = 1'b1;
                else
                    k = a / {129'd0, q.small_operand};
            end
            KIND_XOR:      k = a ^ b;
            KIND_MID:
                k = (ord != ORD_GREATER) ? a + ((b - a) >> 1) : b + ((a - b) >> 1);
            default:       k = '0;
        endcase
        r.r_top = k[159:128];
        r.r_mid = k[127:64];
        r.r_low = k[63:0];
        r.order = ord;
        return r;
    endfunction

    assign pending = want_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        kau_res_t w;
        if (!rst_n)
        begin
            fail_count   <= 0;
            result_count <= 0;
        end
        else
        begin
            if (start && !busy)
                want_q.push_back(key_result(req));
            if (done)
            begin
                result_count <= result_count + 1;
                if (want_q.size() == 0)
                begin
                    $display("%0t unexpected result %h", $time, res);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    w = want_q.pop_front();
                    if (res !== w)
                    begin
                        $display("%0t mismatch expected %h actual %h", $time, w, res);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

### tb/tb.sv
module tb;
    import kau_pkg::*;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    logic     busy;
    logic     done;
    kau_req_t req = '0;
    kau_res_t res;
    int       fail_count;
    int       pending;
    int       result_count;

    always #6 clk = ~clk;

    key_arithmetic_unit_160_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .res   (res)
    );

    kau_checker u_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req          (req),
        .done         (done),
        .res          (res),
        .fail_count   (fail_count),
        .pending      (pending),
        .result_count (result_count)
    );

    function automatic logic [63:0] rand64(input int mode);
        case (mode)
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic kau_req_t random_request();
        kau_req_t q;
        q.kind          = 3'($urandom_range(0, 7));
        q.a_top         = 32'(rand64($urandom_range(0, 7)));
        q.a_mid         = rand64($urandom_range(0, 7));
        q.a_low         = rand64($urandom_range(0, 7));
        q.b_top         = ($urandom_range(0, 3) == 0) ? q.a_top
                                                      : 32'(rand64($urandom_range(0, 7)));
        q.b_mid         = ($urandom_range(0, 3) == 0) ? q.a_mid : rand64($urandom_range(0, 7));
        q.b_low         = ($urandom_range(0, 3) == 0) ? q.a_low : rand64($urandom_range(0, 7));
        case ($urandom_range(0, 5))
            0: q.small_operand = '0;
            1: q.small_operand = 31'($urandom_range(1, 3));
            2: q.small_operand = '1;
            default: q.small_operand = 31'($urandom);
        endcase
        return q;
    endfunction

    task automatic send(input kau_req_t q);
        int gap;
        req   <= q;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        gap = ($urandom_range(0, 9) < 6) ? 0 :
              ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 200);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin
        #20000000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        kau_req_t q;
        int sent;
        sent = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int k = 0; k < 8; k++)
        begin
            q = '0;
            q.kind = 3'(k);
            send(q);
            q = '1;
            q.kind = 3'(k);
            send(q);
            q = random_request();
            q.kind = 3'(k);
            send(q);
            sent += 3;
        end
        q = '0;
        q.kind = KIND_DIV;
        q.a_low = 64'd7;
        q.small_operand = 31'd1;
        send(q);
        sent++;
        for (int n = 0; n < 1900; n++)
        begin
            send(random_request());
            sent++;
        end
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        $display("covered %0d requests over all kinds, %0d results checked", sent, result_count);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### filelist.f
design/kau_pkg.sv
design/kau_front.sv
design/kau_cell.sv
design/key_arithmetic_unit_160_unit.sv
tb/kau_checker.sv
tb/tb.sv
